// ===== rtl/core/distance_rgb_fader_defines.svh =====
// Assertion macros shared by the distance RGB fader RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef DISTANCE_RGB_FADER_DEFINES_SVH
`define DISTANCE_RGB_FADER_DEFINES_SVH

`ifndef ASSERT_OFF
// Same-cycle implication: whenever a holds, c must hold too.
`define DRF_ASSERT_SAME(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("distance_rgb_fader assertion failed");
// Next-cycle implication: whenever a holds, c must hold in the next cycle.
`define DRF_ASSERT_NEXT(label, clk, rst, a, c) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("distance_rgb_fader assertion failed");
`else
`define DRF_ASSERT_SAME(label, clk, rst, a, c)
`define DRF_ASSERT_NEXT(label, clk, rst, a, c)
`endif

`endif

// ===== rtl/core/dfd_pkg.sv =====
// Shared types and constants for the distance RGB fader.
// Used by dfd_lane and distance_rgb_fader; depends on nothing.
package dfd_pkg;

   localparam int MM_W     = 16;
   localparam int DUTY_W   = 8;
   localparam int TIME_W   = 32;
   localparam int STEP_W   = 8;
   localparam int INTVL_W  = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // Clamp window of the distance readings.
   localparam logic [MM_W-1:0] MIN_MM = 16'd20;
   localparam logic [MM_W-1:0] MAX_MM = 16'd500;

   // Dividing by 480 is done as a shift by 5 and a multiply by 2185 / 2**15,
   // which equals floor(x / 15) for every x below 4096.
   localparam logic [11:0] RECIP_15  = 12'd2185;
   localparam int          RECIP_SH  = 15;
   localparam logic [16:0] ROUND_ADD = 17'd240;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] REG_ENABLED      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_STEP_SIZE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_REFRESH_INTV = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_COMMON_ANODE = 2'd3;

   // Control that the top level hands to each colour lane.
   typedef struct packed {
      logic s1_load;  // capture a new reading into the mapping stage
      logic s2_load;  // commit the slew step for the item in the mapping stage
      logic refresh;  // this item replaces the target
   } dfd_lane_ctrl_type;

endpackage

// ===== rtl/core/dfd_lane.sv =====
// One colour lane of the distance RGB fader: distance-to-duty mapping stage
// followed by the target and slew-limited level registers. Depends on dfd_pkg.
module dfd_lane (
   input  logic                            clock,
   input  logic                            reset,
   input  dfd_pkg::dfd_lane_ctrl_type      ctrl,
   input  logic [dfd_pkg::MM_W-1:0]        mm,
   input  logic                            mm_valid,
   input  logic [dfd_pkg::STEP_W-1:0]      step_size,
   output logic [dfd_pkg::DUTY_W-1:0]      level_next
);
   import dfd_pkg::*;

   logic [MM_W-1:0]   clamped;
   logic [8:0]        headroom;
   logic [16:0]       scaled;
   logic [11:0]       coarse;
   logic [23:0]       product;
   logic [DUTY_W-1:0] map_value;

   logic [DUTY_W-1:0] map_ff;
   logic [DUTY_W-1:0] target_ff;
   logic [DUTY_W-1:0] target_in;
   logic [DUTY_W-1:0] level_ff;
   logic [DUTY_W-1:0] level_in;
   logic [DUTY_W:0]   up_sum;
   logic [DUTY_W:0]   down_lim;

   // Stage one: clamp, reverse, scale by 255 and divide by 480 with rounding; an invalid reading maps to zero.
   always_comb begin
      if (mm < MIN_MM) begin
         clamped = MIN_MM;
      end else if (mm > MAX_MM) begin
         clamped = MAX_MM;
      end else begin
         clamped = mm;
      end
      headroom  = 9'(MAX_MM - clamped);
      scaled    = ({headroom, 8'd0} - {8'd0, headroom}) + ROUND_ADD;
      coarse    = scaled[16:5];
      product   = coarse * RECIP_15;
      map_value = mm_valid ? product[RECIP_SH +: DUTY_W] : '0;
   end

   always_ff @(posedge clock) begin
      if (ctrl.s1_load) begin
         map_ff <= map_value;
      end
   end

   // Stage two: take the new target if this beat refreshes, then slew.
   always_comb begin
      target_in = ctrl.refresh ? map_ff : target_ff;
      up_sum    = {1'b0, level_ff} + {1'b0, step_size};
      down_lim  = {1'b0, target_in} + {1'b0, step_size};
      if (level_ff < target_in) begin
         level_in = (up_sum < {1'b0, target_in}) ? up_sum[DUTY_W-1:0] : target_in;
      end else if (level_ff > target_in) begin
         level_in = ({1'b0, level_ff} >= down_lim) ? (level_ff - step_size) : target_in;
      end else begin
         level_in = level_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= '0;
         level_ff  <= '0;
      end else if (ctrl.s2_load) begin
         target_ff <= target_in;
         level_ff  <= level_in;
      end
   end

   assign level_next = level_in;

endmodule

// ===== rtl/core/distance_rgb_fader.sv =====
// Top level of the distance RGB fader: configuration registers, refresh
// timing, three colour lanes and the merging output register.
// Depends on dfd_pkg, dfd_lane and distance_rgb_fader_defines.svh.
//
//   channel  direction  handshake              payload
//   req      in         req_tvalid/req_tready  req_tdata, req_tuser
//   rsp      out        rsp_tvalid/rsp_tready  rsp_tdata, rsp_tuser
//   csr      in         csr_we                 csr_index, csr_wdata
//
// One item is taken every cycle while ready is high; a result passes the
// mapping stage, then the slew and output register stage.
// Reset is synchronous and clears the levels, targets, refresh time and
// all valid flags, and sets the registers to their defaults. Beats taken
// while disabled give no result. A stalled result holds the output register
// and, behind it, the mapping stage; ready drops only when both are full.
`include "distance_rgb_fader_defines.svh"

module distance_rgb_fader (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // time_ms[31:0], left_mm[47:32], front_mm[63:48], right_mm[79:64]
   input  logic [79:0]                       req_tdata,
   // left_valid[0], front_valid[1], right_valid[2]
   input  logic [2:0]                        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // red_duty[7:0], green_duty[15:8], blue_duty[23:16]
   output logic [23:0]                       rsp_tdata,
   // targets_refreshed[0]
   output logic                              rsp_tuser,
   input  logic                              csr_we,
   input  logic [dfd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dfd_pkg::CSR_DAT_W-1:0]     csr_wdata
);
   import dfd_pkg::*;

   localparam int LANES = 3;

   logic               enabled_ff;
   logic [STEP_W-1:0]  step_size_ff;
   logic [INTVL_W-1:0] interval_ff;
   logic               common_anode_ff;

   logic               s1_valid_ff;
   logic [TIME_W-1:0]  s1_time_ff;
   logic [TIME_W-1:0]  last_refresh_ff;

   logic               rsp_valid_ff;
   logic [23:0]        rsp_data_ff;
   logic               rsp_user_ff;

   logic               s2_ready;
   logic               s1_ready;
   logic               req_take;
   logic               s2_adv;
   logic [TIME_W-1:0]  elapsed;
   logic               refresh_now;
   dfd_lane_ctrl_type  lane_ctrl;

   logic [MM_W-1:0]    lane_mm    [LANES];
   logic [DUTY_W-1:0]  lane_level [LANES];
   logic [23:0]        duty_merged;

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff      <= 1'b0;
         step_size_ff    <= 8'd5;
         interval_ff     <= 16'd100;
         common_anode_ff <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            REG_ENABLED:      enabled_ff      <= csr_wdata[0];
            REG_STEP_SIZE:    step_size_ff    <= csr_wdata[STEP_W-1:0];
            REG_REFRESH_INTV: interval_ff     <= csr_wdata[INTVL_W-1:0];
            REG_COMMON_ANODE: common_anode_ff <= csr_wdata[0];
            default: begin
            end
         endcase
      end
   end

   assign s2_ready   = !rsp_valid_ff || rsp_tready;
   assign s1_ready   = !s1_valid_ff || s2_ready;
   assign req_tready = s1_ready;
   assign req_take   = req_tvalid && s1_ready && enabled_ff;
   assign s2_adv     = s1_valid_ff && s2_ready;

   assign elapsed     = s1_time_ff - last_refresh_ff;
   assign refresh_now = elapsed >= {{(TIME_W-INTVL_W){1'b0}}, interval_ff};

   always_comb begin
      lane_ctrl.s1_load = req_take;
      lane_ctrl.s2_load = s2_adv;
      lane_ctrl.refresh = refresh_now;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         last_refresh_ff <= '0;
      end else begin
         if (s1_ready) begin
            s1_valid_ff <= req_take;
         end
         if (s2_adv && refresh_now) begin
            last_refresh_ff <= s1_time_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_time_ff <= req_tdata[TIME_W-1:0];
      end
   end

   assign lane_mm[0] = req_tdata[47:32];
   assign lane_mm[1] = req_tdata[63:48];
   assign lane_mm[2] = req_tdata[79:64];

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      dfd_lane u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (lane_ctrl),
         .mm         (lane_mm[g]),
         .mm_valid   (req_tuser[g]),
         .step_size  (step_size_ff),
         .level_next (lane_level[g])
      );
      assign duty_merged[g*DUTY_W +: DUTY_W] =
         common_anode_ff ? ~lane_level[g] : lane_level[g];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         rsp_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_adv) begin
         rsp_data_ff <= duty_merged;
         rsp_user_ff <= refresh_now;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // A beat taken while disabled must not enter the mapping stage.
   `DRF_ASSERT_NEXT(a_disabled_drop, clock, reset,
      req_tvalid && req_tready && !enabled_ff, !s1_valid_ff)
   // A refreshing beat records its own time as the last refresh.
   `DRF_ASSERT_NEXT(a_refresh_time, clock, reset,
      s2_adv && refresh_now, last_refresh_ff == $past(s1_time_ff))
   // The mapping stage keeps its item while the output register is blocked.
   `DRF_ASSERT_NEXT(a_s1_hold, clock, reset,
      s1_valid_ff && !s2_ready, s1_valid_ff && $stable(s1_time_ff))

endmodule
